>>> rtl/b32asmd_pkg.sv
// Shared operation codes, constants and types for the binary32 arithmetic unit.
package b32asmd_pkg;

   localparam logic [2:0] ACT_ADD = 3'd0;
   localparam logic [2:0] ACT_SUB = 3'd1;
   localparam logic [2:0] ACT_MUL = 3'd2;
   localparam logic [2:0] ACT_DIV = 3'd3;
   localparam logic [2:0] ACT_NEG = 3'd4;

   localparam logic [31:0] QNAN      = 32'h7FC0_0000;
   localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

   localparam int EXP_W = 11;
   localparam int SIG_W = 48;

   localparam logic signed [EXP_W-1:0] ER_MIN  = -11'sd149;
   localparam logic signed [EXP_W-1:0] ER_OVF  = 11'sd105;
   localparam logic signed [EXP_W-1:0] EXP_BIAS = 11'sd150;

   typedef struct packed {
      logic                    sign;
      logic [26:0]             sig;
      logic                    sticky;
      logic signed [EXP_W-1:0] er;
   } rnd_in_type;

endpackage

>>> rtl/binary32_add_sub_mul_div_unit.sv
// Top level of the sequential binary32 add, subtract, multiply, divide and negate unit.
//
//   Channel   Direction   Handshake            Payload
//   req       in          req_valid/req_stall  req_action, req_operand_a, req_operand_b
//   rsp       out         rsp_valid/rsp_stall  rsp_result
//
// One transfer is worked on at a time; special operands and negate go straight to the result.
// Add, subtract and multiply then pass through the normalizing shifter, which shifts right
// by one bit or left by four or one bits. Divide first prenormalizes the operands and then
// runs the 27 steps of the restoring divider.
// Reset clears only the sequencer. A stalled result holds and blocks new transfers.
module binary32_add_sub_mul_div_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result
);
   import b32asmd_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_PREP   = 4'd1;
   localparam logic [3:0] ST_DIV    = 4'd2;
   localparam logic [3:0] ST_MUL    = 4'd3;
   localparam logic [3:0] ST_ADD    = 4'd4;
   localparam logic [3:0] ST_NORM   = 4'd5;
   localparam logic [3:0] ST_DENORM = 4'd6;
   localparam logic [3:0] ST_ROUND  = 4'd7;
   localparam logic [3:0] ST_DONE   = 4'd8;

   logic [3:0]              state_ff, state_in;
   logic [23:0]             ma_ff, ma_in;
   logic [23:0]             mb_ff, mb_in;
   logic signed [EXP_W-1:0] ea_ff, ea_in;
   logic signed [EXP_W-1:0] eb_ff, eb_in;
   logic signed [EXP_W-1:0] er_ff, er_in;
   logic                    sign_ff, sign_in;
   logic                    zsign_ff, zsign_in;
   logic                    effsub_ff, effsub_in;
   logic [SIG_W-1:0]        sig_ff, sig_in;
   logic                    sticky_ff, sticky_in;
   logic [24:0]             rem_ff, rem_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic [31:0]             result_ff, result_in;

   logic [31:0]             opb;
   logic                    a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;
   logic [23:0]             ma_un, mb_un;
   logic signed [EXP_W-1:0] ea_un, eb_un;
   logic                    mag_lt;
   logic                    prod_sign;

   logic signed [EXP_W-1:0] diff;
   logic [26:0]             large27, small27, shifted, bj;
   logic                    align_st;
   logic [27:0]             sum28;
   logic [47:0]             prod;
   logic                    rem_ge;
   logic [24:0]             rem_sub;
   logic signed [EXP_W-1:0] shift_dist;
   logic [4:0]              sh_amt;

   rnd_in_type              rnd;
   logic [31:0]             rnd_result;

   b32asmd_round u_round (
      .rnd    (rnd),
      .result (rnd_result)
   );

   assign opb    = (req_action == ACT_SUB) ? (req_operand_b ^ SIGN_MASK) : req_operand_b;
   assign a_nan  = (req_operand_a[30:23] == 8'hFF) && (req_operand_a[22:0] != 23'd0);
   assign a_inf  = (req_operand_a[30:23] == 8'hFF) && (req_operand_a[22:0] == 23'd0);
   assign a_zero = (req_operand_a[30:0] == 31'd0);
   assign b_nan  = (opb[30:23] == 8'hFF) && (opb[22:0] != 23'd0);
   assign b_inf  = (opb[30:23] == 8'hFF) && (opb[22:0] == 23'd0);
   assign b_zero = (opb[30:0] == 31'd0);
   assign ma_un  = {|req_operand_a[30:23], req_operand_a[22:0]};
   assign mb_un  = {|opb[30:23], opb[22:0]};
   assign ea_un  = (req_operand_a[30:23] != 8'd0) ?
                   ($signed({3'b000, req_operand_a[30:23]}) - EXP_BIAS) : ER_MIN;
   assign eb_un  = (opb[30:23] != 8'd0) ?
                   ($signed({3'b000, opb[30:23]}) - EXP_BIAS) : ER_MIN;
   assign mag_lt    = req_operand_a[30:0] < opb[30:0];
   assign prod_sign = req_operand_a[31] ^ opb[31];

   assign prod = {24'd0, ma_ff} * {24'd0, mb_ff};

   always_comb begin
      rnd.sign   = ((sig_ff == '0) && !sticky_ff) ? zsign_ff : sign_ff;
      rnd.sig    = sig_ff[26:0];
      rnd.sticky = sticky_ff;
      rnd.er     = er_ff;
   end

   always_comb begin
      state_in  = state_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      ea_in     = ea_ff;
      eb_in     = eb_ff;
      er_in     = er_ff;
      sign_in   = sign_ff;
      zsign_in  = zsign_ff;
      effsub_in = effsub_ff;
      sig_in    = sig_ff;
      sticky_in = sticky_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      result_in = result_ff;

      diff     = ea_ff - eb_ff;
      large27  = {ma_ff, 3'b000};
      small27  = {mb_ff, 3'b000};
      if (diff >= 11'sd27) begin
         shifted  = 27'd0;
         align_st = |mb_ff;
      end else begin
         shifted  = small27 >> diff[4:0];
         align_st = |(small27 & ((27'd1 << diff[4:0]) - 27'd1));
      end
      bj    = {shifted[26:1], shifted[0] | align_st};
      sum28 = effsub_ff ? ({1'b0, large27} - {1'b0, bj}) : ({1'b0, large27} + {1'b0, bj});

      rem_ge  = rem_ff >= {1'b0, mb_ff};
      rem_sub = rem_ge ? (rem_ff - {1'b0, mb_ff}) : rem_ff;

      shift_dist = ER_MIN - er_ff;
      sh_amt     = (shift_dist > 11'sd31) ? 5'd31 : shift_dist[4:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sign_in = prod_sign;
               unique case (req_action) inside
                  ACT_ADD, ACT_SUB: begin
                     if (a_nan || b_nan) begin
                        result_in = QNAN;
                        state_in  = ST_DONE;
                     end else if (a_inf && b_inf) begin
                        result_in = (req_operand_a[31] == opb[31]) ? req_operand_a : QNAN;
                        state_in  = ST_DONE;
                     end else if (a_inf) begin
                        result_in = req_operand_a;
                        state_in  = ST_DONE;
                     end else if (b_inf) begin
                        result_in = opb;
                        state_in  = ST_DONE;
                     end else begin
                        if (mag_lt) begin
                           ma_in   = mb_un;
                           mb_in   = ma_un;
                           ea_in   = eb_un;
                           eb_in   = ea_un;
                           sign_in = opb[31];
                        end else begin
                           ma_in   = ma_un;
                           mb_in   = mb_un;
                           ea_in   = ea_un;
                           eb_in   = eb_un;
                           sign_in = req_operand_a[31];
                        end
                        effsub_in = prod_sign;
                        zsign_in  = req_operand_a[31] & opb[31];
                        state_in  = ST_ADD;
                     end
                  end
                  ACT_MUL: begin
                     if (a_nan || b_nan) begin
                        result_in = QNAN;
                        state_in  = ST_DONE;
                     end else if (a_inf || b_inf) begin
                        result_in = (a_zero || b_zero) ? QNAN : {prod_sign, 8'hFF, 23'd0};
                        state_in  = ST_DONE;
                     end else if (a_zero || b_zero) begin
                        result_in = {prod_sign, 31'd0};
                        state_in  = ST_DONE;
                     end else begin
                        ma_in    = ma_un;
                        mb_in    = mb_un;
                        ea_in    = ea_un;
                        eb_in    = eb_un;
                        state_in = ST_MUL;
                     end
                  end
                  ACT_DIV: begin
                     if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
                        result_in = QNAN;
                        state_in  = ST_DONE;
                     end else if (a_inf || b_zero) begin
                        result_in = {prod_sign, 8'hFF, 23'd0};
                        state_in  = ST_DONE;
                     end else if (a_zero || b_inf) begin
                        result_in = {prod_sign, 31'd0};
                        state_in  = ST_DONE;
                     end else begin
                        ma_in    = ma_un;
                        mb_in    = mb_un;
                        ea_in    = ea_un;
                        eb_in    = eb_un;
                        state_in = ST_PREP;
                     end
                  end
                  ACT_NEG: begin
                     result_in = a_nan ? req_operand_a : (req_operand_a ^ SIGN_MASK);
                     state_in  = ST_DONE;
                  end
                  default: begin
                     result_in = QNAN;
                     state_in  = ST_DONE;
                  end
               endcase
            end
         end
         ST_PREP: begin
            if (ma_ff[23] && mb_ff[23]) begin
               rem_in   = {1'b0, ma_ff};
               cnt_in   = 5'd0;
               sig_in   = '0;
               state_in = ST_DIV;
            end else begin
               if (!ma_ff[23]) begin
                  if (ma_ff[23:20] == 4'd0) begin
                     ma_in = {ma_ff[19:0], 4'd0};
                     ea_in = ea_ff - 11'sd4;
                  end else begin
                     ma_in = {ma_ff[22:0], 1'b0};
                     ea_in = ea_ff - 11'sd1;
                  end
               end
               if (!mb_ff[23]) begin
                  if (mb_ff[23:20] == 4'd0) begin
                     mb_in = {mb_ff[19:0], 4'd0};
                     eb_in = eb_ff - 11'sd4;
                  end else begin
                     mb_in = {mb_ff[22:0], 1'b0};
                     eb_in = eb_ff - 11'sd1;
                  end
               end
            end
         end
         ST_DIV: begin
            sig_in = {sig_ff[SIG_W-2:0], rem_ge};
            rem_in = {rem_sub[23:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd26) begin
               sticky_in = (rem_sub != 25'd0);
               er_in     = ea_ff - eb_ff - 11'sd23;
               state_in  = ST_NORM;
            end
         end
         ST_MUL: begin
            sig_in    = prod;
            er_in     = ea_ff + eb_ff + 11'sd3;
            sticky_in = 1'b0;
            state_in  = ST_NORM;
         end
         ST_ADD: begin
            sig_in    = {20'd0, sum28};
            er_in     = ea_ff;
            sticky_in = 1'b0;
            state_in  = ST_NORM;
         end
         ST_NORM: begin
            if (sig_ff[SIG_W-1:27] != '0) begin
               sig_in    = {1'b0, sig_ff[SIG_W-1:1]};
               sticky_in = sticky_ff | sig_ff[0];
               er_in     = er_ff + 11'sd1;
            end else if ((sig_ff[26:23] == 4'd0) && (sig_ff != '0)) begin
               sig_in = {sig_ff[SIG_W-5:0], 4'd0};
               er_in  = er_ff - 11'sd4;
            end else if (!sig_ff[26] && (sig_ff != '0)) begin
               sig_in = {sig_ff[SIG_W-2:0], 1'b0};
               er_in  = er_ff - 11'sd1;
            end else begin
               state_in = ST_DENORM;
            end
         end
         ST_DENORM: begin
            if (er_ff < ER_MIN) begin
               sig_in    = {21'd0, sig_ff[26:0] >> sh_amt};
               sticky_in = sticky_ff | (|(sig_ff[26:0] & ((27'd1 << sh_amt) - 27'd1)));
               er_in     = ER_MIN;
            end
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            result_in = rnd_result;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      ea_ff     <= ea_in;
      eb_ff     <= eb_in;
      er_ff     <= er_in;
      sign_ff   <= sign_in;
      zsign_ff  <= zsign_in;
      effsub_ff <= effsub_in;
      sig_ff    <= sig_in;
      sticky_ff <= sticky_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      result_ff <= result_in;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = (state_ff == ST_DONE);
   assign rsp_result = result_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("Unit took a transfer without going busy.");

   a_no_accept_with_result: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !rsp_valid)
      else $error("Unit is ready while a result is pending.");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (cnt_ff <= 5'd26))
      else $error("Divider step count ran past the last quotient bit.");

   a_round_normalized: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) |-> (sig_ff[SIG_W-1:27] == '0))
      else $error("Significand reached rounding with bits above the mantissa.");
`endif

endmodule

>>> rtl/b32asmd_round.sv
// Round-to-nearest-even and packing of a normalized significand into binary32.
module b32asmd_round (
   input  b32asmd_pkg::rnd_in_type rnd,
   output logic [31:0]             result
);
   import b32asmd_pkg::*;

   logic [23:0]             mant;
   logic                    half;
   logic                    rest;
   logic                    inc;
   logic [24:0]             sum;
   logic [23:0]             m;
   logic signed [EXP_W-1:0] e;
   logic signed [EXP_W-1:0] biased;

   always_comb begin
      mant = rnd.sig[26:3];
      half = rnd.sig[2];
      rest = rnd.sig[1] | rnd.sig[0] | rnd.sticky;
      inc  = half & (rest | mant[0]);
      sum  = {1'b0, mant} + {24'd0, inc};
      if (sum[24]) begin
         m = sum[24:1];
         e = rnd.er + 11'sd1;
      end else begin
         m = sum[23:0];
         e = rnd.er;
      end
      biased = e + EXP_BIAS;
      if (m[23]) begin
         if (e >= ER_OVF) begin
            result = {rnd.sign, 8'hFF, 23'd0};
         end else begin
            result = {rnd.sign, biased[7:0], m[22:0]};
         end
      end else begin
         result = {rnd.sign, 8'd0, m[22:0]};
      end
   end

endmodule
